[rtl/core/led_pkt_pkg.sv]
`timescale 1ns / 1ps

package led_pkt_pkg;

  // Packet byte limit default and fixed protocol constants
  localparam int          MAX_PACKET_BYTES_DEF = 4090;
  localparam logic [10:0] DEFAULT_LPP          = 11'd200;
  localparam logic [12:0] BYTE_COUNT_MAX       = 13'h1FFF;
  localparam logic [10:0] LED_COUNT_MAX        = 11'h7FF;
  localparam logic [7:0]  TPM2_START_HI        = 8'h9C;
  localparam logic [7:0]  TPM2_START_LO        = 8'hDA;
  localparam logic [7:0]  TPM2_END             = 8'h36;
  localparam logic [3:0]  UPDATE_MASK          = 4'hF;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_MODE      = 2'd0;
  localparam logic [1:0] REG_LPP       = 2'd1;
  localparam logic [1:0] REG_LED_COUNT = 2'd2;

  typedef enum logic [1:0] {
    MODE_RAW  = 2'd0,
    MODE_UPD  = 2'd1,
    MODE_TPM2 = 2'd2,
    MODE_OFF  = 2'd3
  } mode_t;

  // Source of an output byte
  typedef enum logic [1:0] {
    SEL_HDR   = 2'd0,
    SEL_COLOR = 2'd1,
    SEL_TRAIL = 2'd2,
    SEL_BARE  = 2'd3
  } sel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
    logic       packet_end;
    logic       item_end;
  } out_t;

  // What one LED produces
  typedef struct packed {
    logic has_hdr;
    logic hdr_div;
    logic color_go;
    logic has_trl;
    logic has_bare;
    logic pend;
  } plan_t;

  typedef struct packed {
    logic       accept;
    logic       div_start;
    logic       emit;
    sel_t       sel;
    logic [2:0] idx;
    logic       last;
    logic       finish;
  } dp_cmd_t;

  typedef struct packed {
    plan_t pre;
    plan_t cur;
    mode_t mode;
    logic  div_busy;
    logic  out_free;
  } dp_stat_t;

endpackage

[rtl/core/led_pkt_div.sv]
`timescale 1ns / 1ps

module led_pkt_div
  import led_pkt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [16:0] dividend,
  input  logic [10:0] divisor,
  output logic        busy,
  output logic [7:0]  quotient
);

  localparam logic [4:0] STEPS = 5'd17;

  logic [4:0]  cnt_r, cnt_nxt;
  logic [10:0] rem_r, rem_nxt;
  logic [10:0] dsr_r, dsr_nxt;
  logic [16:0] quo_r, quo_nxt;
  logic [11:0] rem_sh;
  logic [11:0] rem_sub;
  logic        fits;

  // One restoring step per cycle, quotient bits shift in from the right
  always_comb begin
    rem_sh  = {rem_r, quo_r[16]};
    rem_sub = rem_sh - {1'b0, dsr_r};
    fits    = rem_sh >= {1'b0, dsr_r};
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    dsr_nxt = dsr_r;
    quo_nxt = quo_r;
    if (start) begin
      cnt_nxt = STEPS;
      rem_nxt = '0;
      dsr_nxt = divisor;
      quo_nxt = dividend;
    end else if (cnt_r != 5'd0) begin
      cnt_nxt = cnt_r - 5'd1;
      rem_nxt = fits ? rem_sub[10:0] : rem_sh[10:0];
      quo_nxt = {quo_r[15:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    quo_r <= quo_nxt;
  end

  assign busy     = cnt_r != 5'd0;
  assign quotient = quo_r[7:0];

endmodule

[rtl/core/led_pkt_dp.sv]
`timescale 1ns / 1ps

module led_pkt_dp
  import led_pkt_pkg::*;
#(
  parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  mode_t       mode,
  input  logic [10:0] cfg_lpp,
  input  logic [15:0] cfg_led_count,
  input  in_t         in_data,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  output logic        out_valid,
  output out_t        out_data,
  input  logic        out_stall
);

  localparam int          FIT_LEDS  = (MAX_PACKET_BYTES - 4) / 3;
  localparam logic [16:0] MAX_BYTES = 17'(MAX_PACKET_BYTES);
  localparam logic [16:0] FIT_MAX   = 17'(FIT_LEDS);

  // Frame and packet state
  logic [3:0]  upd_r;
  logic [15:0] pos_r;
  logic [12:0] bcnt_r;
  logic [10:0] plc_r;
  logic [7:0]  frag_r;
  logic        hdr_pend_r;

  // Item held for the duration of its bytes
  in_t         rgb_r;
  plan_t       cur_r;
  logic        frame_last_r;
  logic [12:0] size_r;
  logic [12:0] bcnt_new_r;
  logic [10:0] plc_new_r;

  logic        out_valid_r;
  out_t        out_data_r;

  logic [16:0] eff;
  logic [10:0] lpp;
  logic [16:0] pos_x;
  logic        frame_last;
  logic        hdr_pre;
  logic [12:0] hdr_len;
  logic [12:0] base_b;
  logic [13:0] bsum;
  logic [12:0] bcnt_new;
  logic [10:0] plc_inc;
  logic        color_go;
  logic        pend;
  plan_t       pre;
  logic [16:0] left;
  logic [16:0] leds_a;
  logic [16:0] leds_b;
  logic [12:0] size_new;
  logic [16:0] div_num;
  logic        div_busy;
  logic [7:0]  total;
  logic [7:0]  hdr_byte;
  logic [7:0]  byte_sel;
  out_t        beat;

  // Effective frame length and fragment size
  always_comb begin
    eff     = (cfg_led_count == 16'd0) ? 17'h10000 : {1'b0, cfg_led_count};
    lpp     = (cfg_lpp == 11'd0) ? DEFAULT_LPP : cfg_lpp;
    pos_x   = {1'b0, pos_r};
    div_num = eff + {6'b0, lpp} - 17'd1;
  end

  // Plan the next LED from the current state
  always_comb begin
    frame_last = (pos_x + 17'd1) >= eff;
    hdr_pre    = hdr_pend_r && (mode != MODE_OFF);
    unique case (mode)
      MODE_UPD:  hdr_len = 13'd4;
      MODE_TPM2: hdr_len = 13'd6;
      default:   hdr_len = 13'd0;
    endcase
    base_b   = hdr_pre ? hdr_len : bcnt_r;
    color_go = (mode != MODE_OFF) && ({4'b0, base_b} < MAX_BYTES);
    bsum     = {1'b0, base_b} + (color_go ? 14'd3 : 14'd0);
    bcnt_new = (bsum > {1'b0, BYTE_COUNT_MAX}) ? BYTE_COUNT_MAX : bsum[12:0];
    if (hdr_pre) begin
      plc_inc = 11'd1;
    end else if (plc_r == LED_COUNT_MAX) begin
      plc_inc = plc_r;
    end else begin
      plc_inc = plc_r + 11'd1;
    end
    pend = (mode != MODE_OFF) &&
           (frame_last || ((mode != MODE_RAW) && (plc_inc >= lpp)));
    pre.has_hdr  = hdr_pre && ((mode == MODE_UPD) || (mode == MODE_TPM2));
    pre.hdr_div  = hdr_pre && (mode == MODE_TPM2);
    pre.color_go = color_go;
    pre.has_trl  = pend && (mode == MODE_TPM2);
    pre.has_bare = pend && !pre.has_hdr && !color_go && !pre.has_trl;
    pre.pend     = pend;
  end

  // tpm2.net payload size: LEDs this packet carries, times three
  always_comb begin
    left     = (eff > pos_x) ? (eff - pos_x) : 17'd1;
    leds_a   = (left > {6'b0, lpp}) ? {6'b0, lpp} : left;
    leds_b   = (leds_a > FIT_MAX) ? FIT_MAX : leds_a;
    size_new = {1'b0, leds_b[10:0], 1'b0} + {2'b0, leds_b[10:0]};
  end

  led_pkt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_num),
    .divisor  (lpp),
    .busy     (div_busy),
    .quotient (total)
  );

  // Latch the item at accept, commit its state at finish
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upd_r      <= '0;
      pos_r      <= '0;
      bcnt_r     <= '0;
      plc_r      <= '0;
      frag_r     <= '0;
      hdr_pend_r <= 1'b1;
      cur_r      <= '0;
    end else if (cmd.accept) begin
      cur_r <= pre;
      if (pos_r == 16'd0) begin
        upd_r  <= (upd_r + 4'd1) & UPDATE_MASK;
        frag_r <= '0;
      end
    end else if (cmd.finish) begin
      pos_r <= frame_last_r ? 16'd0 : (pos_r + 16'd1);
      if (mode != MODE_OFF) begin
        bcnt_r     <= bcnt_new_r;
        plc_r      <= plc_new_r;
        hdr_pend_r <= cur_r.pend;
        if (cur_r.pend) begin
          frag_r <= frag_r + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rgb_r        <= in_data;
      frame_last_r <= frame_last;
      size_r       <= size_new;
      bcnt_new_r   <= bcnt_new;
      plc_new_r    <= plc_inc;
    end
  end

  // Pick the header byte for the active mode
  always_comb begin
    hdr_byte = '0;
    if (mode == MODE_TPM2) begin
      case (cmd.idx)
        3'd0:    hdr_byte = TPM2_START_HI;
        3'd1:    hdr_byte = TPM2_START_LO;
        3'd2:    hdr_byte = {3'b0, size_r[12:8]};
        3'd3:    hdr_byte = size_r[7:0];
        3'd4:    hdr_byte = frag_r + 8'd1;
        default: hdr_byte = total;
      endcase
    end else begin
      case (cmd.idx)
        3'd0:    hdr_byte = {4'b0, upd_r};
        3'd1:    hdr_byte = frag_r;
        3'd2:    hdr_byte = pos_r[15:8];
        default: hdr_byte = pos_r[7:0];
      endcase
    end
  end

  always_comb begin
    case (cmd.sel)
      SEL_HDR:   byte_sel = hdr_byte;
      SEL_COLOR: begin
        case (cmd.idx)
          3'd0:    byte_sel = rgb_r.red;
          3'd1:    byte_sel = rgb_r.green;
          default: byte_sel = rgb_r.blue;
        endcase
      end
      SEL_TRAIL: byte_sel = TPM2_END;
      default:   byte_sel = '0;
    endcase
    beat.data_byte  = byte_sel;
    beat.data_valid = cmd.sel != SEL_BARE;
    beat.packet_end = cmd.last && cur_r.pend;
    beat.item_end   = cmd.last;
  end

  // Output register: load a beat, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= beat;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign stat.pre      = pre;
  assign stat.cur      = cur_r;
  assign stat.mode     = mode;
  assign stat.div_busy = div_busy;
  assign stat.out_free = !out_valid_r || !out_stall;

endmodule

[rtl/core/led_pkt_ctrl.sv]
`timescale 1ns / 1ps

module led_pkt_ctrl
  import led_pkt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_HDR,
    S_COLOR,
    S_TRAIL,
    S_BARE,
    S_SKIP
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [2:0] hdr_last;

  function automatic state_t first_state(plan_t p);
    state_t s;
    if (p.hdr_div)       s = S_DIV;
    else if (p.has_hdr)  s = S_HDR;
    else if (p.color_go) s = S_COLOR;
    else if (p.has_trl)  s = S_TRAIL;
    else if (p.has_bare) s = S_BARE;
    else                 s = S_SKIP;
    return s;
  endfunction

  function automatic state_t after_hdr(plan_t p);
    state_t s;
    if (p.color_go)     s = S_COLOR;
    else if (p.has_trl) s = S_TRAIL;
    else                s = S_IDLE;
    return s;
  endfunction

  assign hdr_last = (stat.mode == MODE_TPM2) ? 3'd5 : 3'd3;
  assign in_ready = state_r == S_IDLE;

  // Sequence header, color, trailer and bare-end beats
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    cmd.sel   = SEL_BARE;
    cmd.idx   = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept    = 1'b1;
          cmd.div_start = stat.pre.hdr_div;
          state_nxt     = first_state(stat.pre);
          idx_nxt       = '0;
        end
      end
      S_DIV: begin
        if (!stat.div_busy) begin
          state_nxt = S_HDR;
        end
      end
      S_HDR: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = SEL_HDR;
          if (idx_r == hdr_last) begin
            state_nxt = after_hdr(stat.cur);
            idx_nxt   = '0;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
      end
      S_COLOR: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = SEL_COLOR;
          if (idx_r == 3'd2) begin
            state_nxt = stat.cur.has_trl ? S_TRAIL : S_IDLE;
            idx_nxt   = '0;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
      end
      S_TRAIL: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_TRAIL;
          state_nxt = S_IDLE;
        end
      end
      S_BARE: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_BARE;
          state_nxt = S_IDLE;
        end
      end
      S_SKIP: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    cmd.last   = cmd.emit && (state_nxt == S_IDLE);
    cmd.finish = cmd.finish || cmd.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free)
    else $error("beat loaded while output register is held");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !stat.div_busy)
    else $error("divider restarted while busy");

  a_acc_fin: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.accept && cmd.finish))
    else $error("accept and finish in the same cycle");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && stat.div_busy) |=> state_r == S_DIV)
    else $error("header started before packet total was ready");
`endif

endmodule

[rtl/core/led_frame_udp_packetizer.sv]
`timescale 1ns / 1ps

// LED frame packetizer: one RGB color per input beat, one packet byte per
// output beat, with data_valid, packet_end and item_end flags.
// Input channel in_valid/in_stall carries red, green, blue. Output channel
// out_valid/out_stall carries the byte; a packet end with no byte comes out
// with data_valid low. Registers mode, leds_per_packet and led_count sit on
// the APB port at byte addresses 0, 4 and 8; write them only while idle.
// One LED is taken at a time: the block takes an input only when its
// sequencer is idle. A raw LED is an accept and then three color beats.
// A packet header adds 4 beats in update mode and 6 in tpm2.net mode,
// where the sequencer first waits for the packet total from a 17-step
// bit-serial divider; the trailer adds one beat. Outside that wait, an
// LED's first beat passes the sequencer state and output registers.
// Reset loads mode 0, 200 LEDs per packet and a frame of 1 LED, clears all
// counters and marks a header due. A stalled output beat holds in the output
// register; the sequencer waits and, when not idle, stalls the input side.
module led_frame_udp_packetizer
  import led_pkt_pkg::*;
#(
  parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  mode_t       mode_r;
  logic [10:0] lpp_r;
  logic [15:0] led_count_r;
  logic        cfg_wr;
  logic        in_ready;
  dp_cmd_t     cmd;
  dp_stat_t    stat;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_RAW;
      lpp_r       <= DEFAULT_LPP;
      led_count_r <= 16'd1;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_MODE:      mode_r      <= mode_t'(cfg_pwdata[1:0]);
        REG_LPP:       lpp_r       <= cfg_pwdata[10:0];
        REG_LED_COUNT: led_count_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_MODE:      cfg_prdata = {30'b0, mode_r};
      REG_LPP:       cfg_prdata = {21'b0, lpp_r};
      REG_LED_COUNT: cfg_prdata = {16'b0, led_count_r};
      default:       cfg_prdata = '0;
    endcase
  end

  assign in_stall = !in_ready;

  led_pkt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  led_pkt_dp #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .mode          (mode_r),
    .cfg_lpp       (lpp_r),
    .cfg_led_count (led_count_r),
    .in_data       (in_data),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_data      (out_data),
    .out_stall     (out_stall)
  );

endmodule
